// ----- sv/bmlw_pkg.sv -----
// ----------------------------------------------------------------------------
// bmlw_pkg
// Types and constants shared by the button, mode, LED and watchdog controller.
// ----------------------------------------------------------------------------
package bmlw_pkg;

  // one tick of input
  typedef struct packed {
    logic       button_level;
    logic [1:0] stim_quartile;
    logic       link_activity;
    logic       battery_low;
    logic       debug_hold;
  } tick_t;

  // one result per tick
  typedef struct packed {
    logic led_drive;
    logic stim_active;
    logic hv_charge_enable;
    logic shutdown_active;
    logic save_settings_pulse;
    logic supply_enable;
    logic link_error;
    logic short_press_event;
    logic long_press_event;
    logic button_held;
  } result_t;

  typedef struct packed {
    logic [7:0]  short_press_count;
    logic [7:0]  long_press_count;
    logic [3:0]  fast_blink_base;
    logic [7:0]  slow_blink_ticks;
    logic [3:0]  blink_on_ticks;
    logic [15:0] idle_timeout_ticks;
    logic [15:0] comm_timeout_ticks;
    logic [15:0] supply_off_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_SHORT_PRESS  = 3'd0,
    REG_LONG_PRESS   = 3'd1,
    REG_FAST_BASE    = 3'd2,
    REG_SLOW_BLINK   = 3'd3,
    REG_BLINK_ON     = 3'd4,
    REG_IDLE_TIMEOUT = 3'd5,
    REG_COMM_TIMEOUT = 3'd6,
    REG_SUPPLY_OFF   = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_ON   = 2'd0,
    MODE_OFF  = 2'd1,
    MODE_FAST = 2'd2,
    MODE_SLOW = 2'd3
  } led_mode_t;

  typedef struct packed {
    logic [8:0]  press_counter;
    logic [8:0]  blink_counter;
    led_mode_t   led_mode;
    logic        led_level;
    logic        run_enable;
    logic        hv_enable;
    logic        shutting_down;
    logic        save_pending;
    logic        receive_error_flag;
    logic [16:0] idle_watchdog;
    logic [15:0] shutdown_counter;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    short_press_count:  8'd1,
    long_press_count:   8'd16,
    fast_blink_base:    4'd4,
    slow_blink_ticks:   8'd32,
    blink_on_ticks:     4'd1,
    idle_timeout_ticks: 16'd6000,
    comm_timeout_ticks: 16'd100,
    supply_off_ticks:   16'd1000
  };

  localparam state_t STATE_RESET = '{
    press_counter:      9'd0,
    blink_counter:      9'd0,
    led_mode:           MODE_ON,
    led_level:          1'b0,
    run_enable:         1'b0,
    hv_enable:          1'b0,
    shutting_down:      1'b0,
    save_pending:       1'b0,
    receive_error_flag: 1'b0,
    idle_watchdog:      17'd6000,
    shutdown_counter:   16'd0
  };

  localparam logic [15:0] SHUTDOWN_COUNT_MAX = 16'hFFFF;

endpackage

// ----- sv/button_mode_led_watchdog_ctrl.sv -----
// ----------------------------------------------------------------------------
// button_mode_led_watchdog_ctrl
// Push-button mode control, LED blinking, idle watchdog and shutdown sequencing.
// ----------------------------------------------------------------------------
// Each transfer on the tick channel is one tick and gives exactly one result.
// A tick is captured in an input register, passes once through the next-state
// logic and lands in the result register, which presents it on the result
// channel; the block sustains one tick per clock while result_stall is low,
// and a new tick can be taken into the input register while the previous
// result still waits on result_stall. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and must only be changed while no tick
// is in flight.
module button_mode_led_watchdog_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  bmlw_pkg::tick_t     tick,
  output logic                result_valid,
  input  logic                result_stall,
  output bmlw_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  bmlw_pkg::cfg_t    cfg;
  bmlw_pkg::state_t  st;
  bmlw_pkg::state_t  st_next;
  bmlw_pkg::tick_t   tick_q;
  bmlw_pkg::result_t res_next;
  logic              tick_q_valid;
  logic              advance;

  assign advance    = tick_q_valid && (!result_valid || !result_stall);
  assign tick_stall = tick_q_valid && !advance;

  bmlw_step u_step (
    .cfg     (cfg),
    .st      (st),
    .tick    (tick_q),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bmlw_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (bmlw_pkg::cfg_index_t'(cfg_index))
        bmlw_pkg::REG_SHORT_PRESS:  cfg.short_press_count  <= cfg_data[7:0];
        bmlw_pkg::REG_LONG_PRESS:   cfg.long_press_count   <= cfg_data[7:0];
        bmlw_pkg::REG_FAST_BASE:    cfg.fast_blink_base    <= cfg_data[3:0];
        bmlw_pkg::REG_SLOW_BLINK:   cfg.slow_blink_ticks   <= cfg_data[7:0];
        bmlw_pkg::REG_BLINK_ON:     cfg.blink_on_ticks     <= cfg_data[3:0];
        bmlw_pkg::REG_IDLE_TIMEOUT: cfg.idle_timeout_ticks <= cfg_data;
        bmlw_pkg::REG_COMM_TIMEOUT: cfg.comm_timeout_ticks <= cfg_data;
        bmlw_pkg::REG_SUPPLY_OFF:   cfg.supply_off_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= bmlw_pkg::STATE_RESET;
      tick_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (tick_valid && !tick_stall) begin
        tick_q_valid <= 1'b1;
      end else if (advance) begin
        tick_q_valid <= 1'b0;
      end
      if (advance) begin
        st           <= st_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) tick_q <= tick;
    if (advance)                   result <= res_next;
  end

endmodule

// ----- sv/bmlw_step.sv -----
// ----------------------------------------------------------------------------
// bmlw_step
// Next-state and result logic for one tick of the controller.
// ----------------------------------------------------------------------------
module bmlw_step (
  input  bmlw_pkg::cfg_t    cfg,
  input  bmlw_pkg::state_t  st,
  input  bmlw_pkg::tick_t   tick,
  output bmlw_pkg::state_t  st_next,
  output bmlw_pkg::result_t res
);

  always_comb begin
    logic [8:0]  pc;
    logic [8:0]  bc;
    logic [8:0]  lim;
    logic [3:0]  off;
    logic [16:0] wd;
    logic [15:0] sdc;
    logic        ev_short;
    logic        ev_long;
    logic        run;
    logic        hv;
    logic        sd;
    logic        save;
    logic        err;
    logic        do_sd;
    logic        pulse;
    logic        lvl;
    bmlw_pkg::led_mode_t mode;

    pc       = st.press_counter;
    bc       = st.blink_counter;
    wd       = st.idle_watchdog;
    sdc      = st.shutdown_counter;
    run      = st.run_enable;
    hv       = st.hv_enable;
    sd       = st.shutting_down;
    save     = st.save_pending;
    err      = st.receive_error_flag;
    lvl      = st.led_level;
    mode     = st.led_mode;
    ev_short = 1'b0;
    ev_long  = 1'b0;
    pulse    = 1'b0;
    lim      = 9'd0;
    off      = 4'd0;

    // press counter: up while held, down after release
    if (!tick.button_level) begin
      if (pc != 9'd0) begin
        pc = pc - 9'd1;
        if (pc == {1'b0, cfg.short_press_count}) begin
          ev_short = 1'b1;
          pc       = 9'd0;
        end else if (pc == {1'b0, cfg.long_press_count}) begin
          pc = 9'd0;
        end
      end
    end else begin
      if (pc <= {1'b0, cfg.long_press_count}) pc = pc + 9'd1;
      if (pc == {1'b0, cfg.long_press_count}) ev_long = 1'b1;
    end

    if (ev_short) begin
      run = ~run;
      hv  = run;
      err = 1'b0;
      sd  = 1'b0;
    end else if (ev_long) begin
      if (run) save = 1'b1;
      run = 1'b0;
      sd  = 1'b1;
    end

    if (tick.link_activity) begin
      wd = {1'b0, cfg.idle_timeout_ticks} + {1'b0, cfg.comm_timeout_ticks};
    end

    do_sd = sd;
    if (!tick.debug_hold) begin
      if (wd == 17'd0) do_sd = 1'b1;
      else             wd = wd - 17'd1;
      if (tick.battery_low) do_sd = 1'b1;
      // error set on an earlier tick stops stimulation
      if (err) run = 1'b0;
      if (wd == {1'b0, cfg.idle_timeout_ticks}) err = 1'b1;
    end

    if (do_sd) begin
      sd = 1'b1;
      if (save) begin
        save  = 1'b0;
        pulse = 1'b1;
      end
      if (sdc != bmlw_pkg::SHUTDOWN_COUNT_MAX) sdc = sdc + 16'd1;
    end

    if (sd) begin
      mode = (mode == bmlw_pkg::MODE_ON) ? bmlw_pkg::MODE_OFF : bmlw_pkg::MODE_ON;
    end else begin
      mode = run ? bmlw_pkg::MODE_FAST : bmlw_pkg::MODE_SLOW;
    end

    unique case (mode)
      bmlw_pkg::MODE_ON:  lvl = 1'b1;
      bmlw_pkg::MODE_OFF: lvl = 1'b0;
      bmlw_pkg::MODE_FAST: begin
        off = (cfg.fast_blink_base > {2'b00, tick.stim_quartile}) ?
              cfg.fast_blink_base - {2'b00, tick.stim_quartile} : 4'd0;
        lim = {5'd0, off} + {5'd0, cfg.blink_on_ticks};
        bc  = bc + 9'd1;
        // on wrap the led keeps its level
        if (bc > lim) bc = 9'd0;
        else          lvl = (bc > {5'd0, off});
      end
      bmlw_pkg::MODE_SLOW: begin
        lim = {1'b0, cfg.slow_blink_ticks} + {5'd0, cfg.blink_on_ticks};
        bc  = bc + 9'd1;
        if (bc > lim) bc = 9'd0;
        else          lvl = (bc >= {1'b0, cfg.slow_blink_ticks});
      end
      default: lvl = 1'b0;
    endcase

    st_next.press_counter      = pc;
    st_next.blink_counter      = bc;
    st_next.led_mode           = mode;
    st_next.led_level          = lvl;
    st_next.run_enable         = run;
    st_next.hv_enable          = hv;
    st_next.shutting_down      = sd;
    st_next.save_pending       = save;
    st_next.receive_error_flag = err;
    st_next.idle_watchdog      = wd;
    st_next.shutdown_counter   = sdc;

    res.led_drive           = lvl;
    res.stim_active         = run;
    res.hv_charge_enable    = hv & ~sd;
    res.shutdown_active     = sd;
    res.save_settings_pulse = pulse;
    res.supply_enable       = !(sdc > cfg.supply_off_ticks);
    res.link_error          = err;
    res.short_press_event   = ev_short;
    res.long_press_event    = ev_long;
    res.button_held         = tick.button_level;
  end

endmodule

// ----- sv/bmlw_checker.sv -----
// ----------------------------------------------------------------------------
// bmlw_checker
// Port-level checks for the controller, bound to the top level.
// ----------------------------------------------------------------------------
module bmlw_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input bmlw_pkg::result_t result
);

  // a stalled result transfer holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_hv_off_in_shutdown: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.hv_charge_enable && result.shutdown_active))
    else $error("high voltage enabled during shutdown");

  // short press only on release, never together with a long press
  a_short_on_release: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.short_press_event |->
      !result.button_held && !result.long_press_event)
    else $error("short press while held or with long press");

  a_save_in_shutdown: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.save_settings_pulse |-> result.shutdown_active)
    else $error("save request outside shutdown");

endmodule

bind button_mode_led_watchdog_ctrl bmlw_checker u_bmlw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
